/* rtl/asr_pkg.sv */
// Shared types and constants for the ARM status register unit.
// Holds status codes, instruction kinds, PSR bit positions and the
// structs passed between the execute logic, the state bank and the top.
`timescale 1ns / 1ps
`default_nettype none

package asr_pkg;

    // instruction kinds
    localparam logic [1:0] K_MRS = 2'd0;
    localparam logic [1:0] K_MSR = 2'd1;
    localparam logic [1:0] K_CPS = 2'd2;

    // result status codes
    localparam logic [3:0] ST_DONE   = 4'd0;
    localparam logic [3:0] ST_COND   = 4'd1;
    localparam logic [3:0] ST_IMOD   = 4'd2;
    localparam logic [3:0] ST_PC     = 4'd3;
    localparam logic [3:0] ST_NOSPSR = 4'd4;
    localparam logic [3:0] ST_TTOG   = 4'd5;
    localparam logic [3:0] ST_ETOG   = 4'd6;
    localparam logic [3:0] ST_AF     = 4'd7;
    localparam logic [3:0] ST_FIQ    = 4'd8;
    localparam logic [3:0] ST_MODE   = 4'd9;
    localparam logic [3:0] ST_USER   = 4'd10;

    // processor modes
    localparam logic [4:0] MODE_USR = 5'h10;
    localparam logic [4:0] MODE_FIQ = 5'h11;
    localparam logic [4:0] MODE_IRQ = 5'h12;
    localparam logic [4:0] MODE_SVC = 5'h13;
    localparam logic [4:0] MODE_ABT = 5'h17;
    localparam logic [4:0] MODE_UND = 5'h1B;

    // PSR bit positions
    localparam int BIT_T = 5;
    localparam int BIT_F = 6;
    localparam int BIT_I = 7;
    localparam int BIT_A = 8;
    localparam int BIT_E = 9;

    localparam logic [31:0] CPSR_RESET = 32'h0000_01D3;
    localparam int          NUM_BANKS  = 5;
    localparam logic [3:0]  REG_PC     = 4'hF;

    // state update requested by one instruction
    typedef struct packed {
        logic        cpsr_we;
        logic        spsr_we;
        logic        latch_we;
        logic [31:0] cpsr_val;
        logic [31:0] spsr_val;
        logic        latch_val;
    } t_upd;

    // one result word
    typedef struct packed {
        logic [31:0] dest_value;
        logic [3:0]  dest_index;
        logic        dest_write;
        logic [31:0] next_pc;
        logic [3:0]  status;
        logic        irq_flag;
    } t_res;

    // view of the state bank seen by the execute logic
    typedef struct packed {
        logic [31:0] cpsr;
        logic [31:0] spsr;
        logic        spsr_ok;
        logic        latch;
        logic        ttc;
    } t_state;

endpackage

`default_nettype wire

/* rtl/arm_status_register_unit.sv */
// ARM status register unit: MRS, MSR and CPS against CPSR and banked SPSRs.
// An accepted item is held in the input register until it fires; its result is then loaded into the result register.
// Throughput: one word per cycle while the output is not stalled; the state bank updates as the result is registered.
// Reset (synchronous, active low): CPSR 0x000001D3, all SPSRs zero, IRQ latch clear,
// thumb toggle check on, both pipeline registers empty.
// Depends on asr_pkg, asr_exec and asr_bank.
`timescale 1ns / 1ps
`default_nettype none

module arm_status_register_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_data,
    // input channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic [31:0] i_instruction_word,
    input  wire logic [31:0] i_source_value,
    input  wire logic [31:0] i_current_pc,
    input  wire logic        i_irq_line,
    input  wire logic        i_fiq_line,
    // output channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_dest_value,
    output logic [3:0]       o_dest_index,
    output logic             o_dest_write,
    output logic [31:0]      o_next_pc,
    output logic [3:0]       o_status,
    output logic             o_irq_pending_flag
);

    logic                r_in_valid;
    logic [1:0]          r_kind;
    logic [31:0]         r_instr;
    logic [31:0]         r_src;
    logic [31:0]         r_pc;
    logic                r_irq;
    logic                r_fiq;

    logic                r_out_valid;
    asr_pkg::t_res       r_res;

    logic                advance;
    logic                fire;
    logic                take_in;
    asr_pkg::t_state     state;
    asr_pkg::t_upd       upd;
    asr_pkg::t_res       res;

    assign advance     = !r_out_valid || !i_stall;
    assign fire        = r_in_valid && advance;
    assign o_stall     = r_in_valid && !advance;
    assign take_in     = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take_in) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_kind  <= i_kind;
            r_instr <= i_instruction_word;
            r_src   <= i_source_value;
            r_pc    <= i_current_pc;
            r_irq   <= i_irq_line;
            r_fiq   <= i_fiq_line;
        end
    end

    asr_exec u_exec (
        .i_kind             (r_kind),
        .i_instruction_word (r_instr),
        .i_source_value     (r_src),
        .i_current_pc       (r_pc),
        .i_irq_line         (r_irq),
        .i_fiq_line         (r_fiq),
        .i_state            (state),
        .o_upd              (upd),
        .o_res              (res)
    );

    asr_bank u_bank (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_commit   (fire),
        .i_upd      (upd),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_state    (state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    // hold the result while stalled
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= res;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_dest_value       = r_res.dest_value;
    assign o_dest_index       = r_res.dest_index;
    assign o_dest_write       = r_res.dest_write;
    assign o_next_pc          = r_res.next_pc;
    assign o_status           = r_res.status;
    assign o_irq_pending_flag = r_res.irq_flag;

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("input stalled without a blocked item");

    a_one_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |-> !(upd.cpsr_we && upd.spsr_we))
        else $error("CPSR and SPSR written by one instruction");

    a_error_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && res.status != asr_pkg::ST_DONE) |-> !(upd.cpsr_we || upd.spsr_we
                                                      || upd.latch_we))
        else $error("failing instruction updated state");

    a_dest_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_dest_write) |-> (o_dest_value == 32'd0 && o_dest_index == 4'd0))
        else $error("destination fields set without a write");

    a_write_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_dest_write) |-> (o_status == asr_pkg::ST_DONE
                                       && o_dest_index != asr_pkg::REG_PC))
        else $error("register write on a failing or PC-target MRS");

endmodule

`default_nettype wire

/* rtl/asr_bank.sv */
// State bank: current PSR, five banked saved PSRs, IRQ latch and the
// thumb toggle check register. Depends on asr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module asr_bank (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_commit,
    input  wire asr_pkg::t_upd   i_upd,
    input  wire logic            i_cfg_we,
    input  wire logic            i_cfg_data,
    output asr_pkg::t_state      o_state
);

    logic [31:0] r_cpsr;
    logic [31:0] r_spsr [asr_pkg::NUM_BANKS];
    logic        r_latch;
    logic        r_ttc;

    logic [2:0]  bank_idx;
    logic        bank_ok;

    // select the saved PSR of the current mode
    always_comb begin
        bank_idx = 3'd0;
        bank_ok  = 1'b1;
        case (r_cpsr[4:0])
            asr_pkg::MODE_FIQ: bank_idx = 3'd0;
            asr_pkg::MODE_IRQ: bank_idx = 3'd1;
            asr_pkg::MODE_SVC: bank_idx = 3'd2;
            asr_pkg::MODE_ABT: bank_idx = 3'd3;
            asr_pkg::MODE_UND: bank_idx = 3'd4;
            default:           bank_ok  = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpsr  <= asr_pkg::CPSR_RESET;
            r_latch <= 1'b0;
            r_ttc   <= 1'b1;
            for (int k = 0; k < asr_pkg::NUM_BANKS; k++) begin
                r_spsr[k] <= 32'd0;
            end
        end else begin
            if (i_cfg_we) begin
                r_ttc <= i_cfg_data;
            end
            if (i_commit && i_upd.cpsr_we) begin
                r_cpsr <= i_upd.cpsr_val;
            end
            if (i_commit && i_upd.spsr_we && bank_ok) begin
                r_spsr[bank_idx] <= i_upd.spsr_val;
            end
            if (i_commit && i_upd.latch_we) begin
                r_latch <= i_upd.latch_val;
            end
        end
    end

    assign o_state.cpsr    = r_cpsr;
    assign o_state.spsr    = r_spsr[bank_idx];
    assign o_state.spsr_ok = bank_ok;
    assign o_state.latch   = r_latch;
    assign o_state.ttc     = r_ttc;

endmodule

`default_nettype wire

/* rtl/asr_exec.sv */
// Execute logic for MRS, MSR and CPS: condition test, immediate
// expansion, byte-field merges and mask updates. Depends on asr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module asr_exec (
    input  wire logic [1:0]     i_kind,
    input  wire logic [31:0]    i_instruction_word,
    input  wire logic [31:0]    i_source_value,
    input  wire logic [31:0]    i_current_pc,
    input  wire logic           i_irq_line,
    input  wire logic           i_fiq_line,
    input  wire asr_pkg::t_state i_state,
    output asr_pkg::t_upd       o_upd,
    output asr_pkg::t_res       o_res
);

    function automatic logic cond_pass(input logic [3:0] cc, input logic [3:0] nzcv);
        logic n, z, c, v, r;
        n = nzcv[3];
        z = nzcv[2];
        c = nzcv[1];
        v = nzcv[0];
        case (cc)
            4'd0:    r = z;
            4'd1:    r = !z;
            4'd2:    r = c;
            4'd3:    r = !c;
            4'd4:    r = n;
            4'd5:    r = !n;
            4'd6:    r = v;
            4'd7:    r = !v;
            4'd8:    r = c && !z;
            4'd9:    r = !c || z;
            4'd10:   r = (n == v);
            4'd11:   r = (n != v);
            4'd12:   r = !z && (n == v);
            4'd13:   r = z || (n != v);
            default: r = 1'b1;
        endcase
        return r;
    endfunction

    // rotate the 8-bit immediate right by twice the rotate field
    function automatic logic [31:0] expand_imm(input logic [11:0] imm12);
        logic [63:0] dbl;
        logic [4:0]  rot;
        dbl = {24'd0, imm12[7:0], 24'd0, imm12[7:0]};
        rot = {imm12[11:8], 1'b0};
        dbl = dbl >> rot;
        return dbl[31:0];
    endfunction

    logic [31:0] instr;
    logic [31:0] cpsr;
    logic        priv;
    logic        cond;
    logic [3:0]  rd;
    logic [3:0]  fmask;
    logic        use_spsr;
    logic [31:0] value;
    logic [31:0] old_psr;
    logic [31:0] new_psr;
    logic [1:0]  imod;
    logic        sel_a;
    logic        sel_i;
    logic        sel_f;
    logic [31:0] psr;
    logic        latch;
    logic [3:0]  st;

    assign instr    = i_instruction_word;
    assign cpsr     = i_state.cpsr;
    assign priv     = (cpsr[4:0] != asr_pkg::MODE_USR);
    assign cond     = cond_pass(instr[31:28], cpsr[31:28]);
    assign rd       = instr[15:12];
    assign fmask    = instr[19:16];
    assign use_spsr = instr[22];
    assign value    = instr[25] ? expand_imm(instr[11:0]) : i_source_value;
    assign old_psr  = use_spsr ? i_state.spsr : cpsr;
    assign imod     = instr[19:18];
    assign sel_a    = instr[8];
    assign sel_i    = instr[7];
    assign sel_f    = instr[6];

    // field merge for MSR; control, extension and status bytes need privilege
    always_comb begin
        new_psr = old_psr;
        if (fmask[0] && priv) new_psr[7:0]   = value[7:0];
        if (fmask[1] && priv) new_psr[15:8]  = value[15:8];
        if (fmask[2] && priv) new_psr[23:16] = value[23:16];
        if (fmask[3])         new_psr[31:24] = value[31:24];
    end

    always_comb begin
        o_upd            = '0;
        o_res            = '0;
        o_res.next_pc    = i_current_pc + 32'd4;
        st               = asr_pkg::ST_DONE;
        psr              = cpsr;
        latch            = i_state.latch;
        case (i_kind)
            asr_pkg::K_MRS: begin
                if (rd == asr_pkg::REG_PC) begin
                    st = asr_pkg::ST_PC;
                end else if (!cond) begin
                    st = asr_pkg::ST_COND;
                end else if (use_spsr && !i_state.spsr_ok) begin
                    st = asr_pkg::ST_NOSPSR;
                end else begin
                    o_res.dest_value = old_psr;
                    o_res.dest_index = rd;
                    o_res.dest_write = 1'b1;
                end
            end
            asr_pkg::K_MSR: begin
                if (!cond) begin
                    st = asr_pkg::ST_COND;
                end else if (!instr[25] && (instr[3:0] == asr_pkg::REG_PC)) begin
                    st = asr_pkg::ST_PC;
                end else if (use_spsr && !i_state.spsr_ok) begin
                    st = asr_pkg::ST_NOSPSR;
                end else if (fmask[0] && priv && i_state.ttc
                             && (old_psr[asr_pkg::BIT_T] != value[asr_pkg::BIT_T])) begin
                    st = asr_pkg::ST_TTOG;
                end else if (fmask[1] && priv
                             && (old_psr[asr_pkg::BIT_E] != value[asr_pkg::BIT_E])) begin
                    st = asr_pkg::ST_ETOG;
                end else begin
                    o_upd.cpsr_we  = !use_spsr;
                    o_upd.spsr_we  = use_spsr;
                    o_upd.cpsr_val = new_psr;
                    o_upd.spsr_val = new_psr;
                end
            end
            asr_pkg::K_CPS: begin
                if (!imod[1]) begin
                    st = asr_pkg::ST_IMOD;
                end else if (!priv) begin
                    st = asr_pkg::ST_USER;
                end else if (!imod[0]) begin
                    // enable: clear selected I and F masks; a selected A must already be clear
                    if (sel_a && cpsr[asr_pkg::BIT_A]) begin
                        st = asr_pkg::ST_AF;
                    end else if (sel_f && cpsr[asr_pkg::BIT_F] && i_fiq_line) begin
                        st = asr_pkg::ST_FIQ;
                    end
                    if (sel_i) begin
                        if (cpsr[asr_pkg::BIT_I] && i_irq_line) latch = 1'b1;
                        psr[asr_pkg::BIT_I] = 1'b0;
                    end
                    if (sel_f) psr[asr_pkg::BIT_F] = 1'b0;
                end else begin
                    // disable: A and F must already be set
                    if ((sel_a && !cpsr[asr_pkg::BIT_A])
                        || (sel_f && !cpsr[asr_pkg::BIT_F])) begin
                        st = asr_pkg::ST_AF;
                    end
                    if (sel_i) begin
                        if (!cpsr[asr_pkg::BIT_I]) latch = 1'b0;
                        psr[asr_pkg::BIT_I] = 1'b1;
                    end
                end
                if (st == asr_pkg::ST_DONE && instr[17]) begin
                    st = asr_pkg::ST_MODE;
                end
                if (st == asr_pkg::ST_DONE) begin
                    o_upd.cpsr_we   = 1'b1;
                    o_upd.cpsr_val  = psr;
                    o_upd.latch_we  = 1'b1;
                    o_upd.latch_val = latch;
                end
            end
            default: ;
        endcase
        o_res.status   = st;
        o_res.irq_flag = o_upd.latch_we ? o_upd.latch_val : i_state.latch;
    end

endmodule

`default_nettype wire
